@@ hdl/c850u_pkg.sv @@
`default_nettype none

package c850u_pkg;

  // Unicode code points of the upper half of code page 850, indexed by byte minus 0x80.
  localparam logic [15:0] CP850_UPPER [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00F8, 16'h00A3, 16'h00D8, 16'h00D7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h00AE, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h00C1, 16'h00C2, 16'h00C0,
    16'h00A9, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h00A2, 16'h00A5, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h00E3, 16'h00C3,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h00A4,
    16'h00F0, 16'h00D0, 16'h00CA, 16'h00CB, 16'h00C8, 16'h0131, 16'h00CD, 16'h00CE,
    16'h00CF, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h00A6, 16'h00CC, 16'h2580,
    16'h00D3, 16'h00DF, 16'h00D4, 16'h00D2, 16'h00F5, 16'h00D5, 16'h00B5, 16'h00FE,
    16'h00DE, 16'h00DA, 16'h00DB, 16'h00D9, 16'h00FD, 16'h00DD, 16'h00AF, 16'h00B4,
    16'h00AD, 16'h00B1, 16'h2017, 16'h00BE, 16'h00B6, 16'h00A7, 16'h00F7, 16'h00B8,
    16'h00B0, 16'h00A8, 16'h00B7, 16'h00B9, 16'h00B3, 16'h00B2, 16'h25A0, 16'h00A0
  };

  localparam logic [15:0] OneByteLimit = 16'h0080;
  localparam logic [15:0] TwoByteLimit = 16'h0800;
  localparam logic [2:0]  Lead2Tag     = 3'b110;
  localparam logic [3:0]  Lead3Tag     = 4'b1110;
  localparam logic [1:0]  ContTag      = 2'b10;

  // Index of the final byte of a run.
  typedef enum logic [1:0] {
    LAST_IS_0 = 2'd0,
    LAST_IS_1 = 2'd1,
    LAST_IS_2 = 2'd2
  } last_idx_e;

  // One encoded character: up to three bytes in transmission order.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    last_idx_e       last_idx;
  } run_t;

endpackage

`default_nettype wire

@@ hdl/cp850_to_utf8_transcoder_core.sv @@
`default_nettype none

// Code page 850 to UTF-8 transcoder. Each input item is one code page 850 byte; the block
// returns its UTF-8 encoding as one to three output items, one byte each, with last_of_char_o
// set on the final byte of the character. ASCII bytes pass through as one item; upper-half
// bytes become two or three items through a fixed 128-entry code point table. Items move on
// valid/stall handshakes and are taken when valid is high and stall is low. The block has
// three register stages (input, run, output), so the first byte of a character passes through
// the input and run registers into the output register before it can leave. Throughput is
// set by the one-byte output register draining the run register: an ASCII item every cycle
// while the output does not stall, while an upper-half item holds the run register until its
// last byte has moved on. There is no state between characters and nothing to configure.
module cp850_to_utf8_transcoder_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,

  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] code_byte_i,

  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      utf8_byte_o,
  output logic            last_of_char_o
);
  import c850u_pkg::*;

  // Input register.
  logic       a_vld_q;
  logic [7:0] a_code_q;

  // Run register: the encoded character and the index of the byte to send next.
  logic       b_vld_q;
  run_t       b_run_q;
  logic [1:0] b_idx_q, b_idx_d;

  // Output register.
  logic       o_vld_q;
  logic [7:0] o_byte_q;
  logic       o_last_q;

  run_t enc_run;
  logic o_load, b_last, b_free, a_free, in_take;

  c850u_encode u_encode (
    .code_i (a_code_q),
    .run_o  (enc_run)
  );

  // The output register takes a byte whenever it is empty or its byte leaves this cycle.
  assign o_load = b_vld_q && (!o_vld_q || !out_stall_i);
  // The run register frees up once its final byte moves to the output register.
  assign b_last = (b_idx_q == b_run_q.last_idx);
  assign b_free = !b_vld_q || (o_load && b_last);
  // The input register hands its byte on as soon as the run register frees up.
  assign a_free = !a_vld_q || b_free;
  assign in_take = in_valid_i && a_free;

  assign in_stall_o = !a_free;

  always_comb begin
    b_idx_d = b_idx_q;
    if (b_free) begin
      b_idx_d = '0;
    end else if (o_load) begin
      b_idx_d = b_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      b_idx_q <= '0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_vld_q <= in_valid_i;
      end
      if (b_free) begin
        b_vld_q <= a_vld_q;
      end
      b_idx_q <= b_idx_d;
      if (!o_vld_q || !out_stall_i) begin
        o_vld_q <= b_vld_q;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      a_code_q <= code_byte_i;
    end
    if (b_free && a_vld_q) begin
      b_run_q <= enc_run;
    end
    if (o_load) begin
      o_byte_q <= b_run_q.bytes[b_idx_q];
      o_last_q <= b_last;
    end
  end

  assign out_valid_o    = o_vld_q;
  assign utf8_byte_o    = o_byte_q;
  assign last_of_char_o = o_last_q;

endmodule

`default_nettype wire

@@ hdl/c850u_encode.sv @@
`default_nettype none

module c850u_encode (
  input  wire logic [7:0]    code_i,
  output c850u_pkg::run_t    run_o
);
  import c850u_pkg::*;

  logic [15:0] cp;

  assign cp = CP850_UPPER[code_i[6:0]];

  always_comb begin
    run_o.bytes    = '0;
    run_o.last_idx = LAST_IS_0;
    if (!code_i[7]) begin
      run_o.bytes[0] = code_i;
    end else if (cp < OneByteLimit) begin
      run_o.bytes[0] = cp[7:0];
    end else if (cp < TwoByteLimit) begin
      run_o.bytes[0] = {Lead2Tag, cp[10:6]};
      run_o.bytes[1] = {ContTag, cp[5:0]};
      run_o.last_idx = LAST_IS_1;
    end else begin
      run_o.bytes[0] = {Lead3Tag, cp[15:12]};
      run_o.bytes[1] = {ContTag, cp[11:6]};
      run_o.bytes[2] = {ContTag, cp[5:0]};
      run_o.last_idx = LAST_IS_2;
    end
  end

endmodule

`default_nettype wire

@@ hdl/c850u_checker.sv @@
`default_nettype none

module c850u_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_stall_o,
  input wire logic [7:0] code_byte_i,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] utf8_byte_o,
  input wire logic       last_of_char_o
);

  // A stalled input item holds its payload.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(code_byte_i))
    else $error("stalled input item changed");

  // A stalled output item holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(utf8_byte_o) && $stable(last_of_char_o))
    else $error("stalled output item changed");

  // A plain ASCII byte is always a whole character.
  a_ascii_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !utf8_byte_o[7] |-> last_of_char_o)
    else $error("ASCII byte not marked last");

  // A lead byte never ends a character.
  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (utf8_byte_o[7:6] == 2'b11) |-> !last_of_char_o)
    else $error("lead byte marked last");

  // Every non-final byte is a lead or a continuation byte.
  a_mid_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_char_o |-> utf8_byte_o[7])
    else $error("non-final byte is not part of a multi-byte sequence");

endmodule

bind cp850_to_utf8_transcoder_core c850u_checker u_c850u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .code_byte_i    (code_byte_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .utf8_byte_o    (utf8_byte_o),
  .last_of_char_o (last_of_char_o)
);

`default_nettype wire

@@ tb/tb_cp850_to_utf8_transcoder_core.sv @@
`timescale 1ns / 100ps

module tb_cp850_to_utf8_transcoder_core;
  import c850u_pkg::*;

  localparam int unsigned CycleLimit = 50000;
  localparam int unsigned LongHoldCycles = 60;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] code_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] utf8_byte_o;
  logic       last_of_char_o;

  // Holds the UTF-8 bytes still owed for the characters taken so far. Each character is
  // encoded when its item is accepted, and every output item must match the oldest byte.
  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] octet;
      logic       last_flag;
    } octet_t;

    octet_t owed_q[$];
    int     mismatches;
    int     ascii_chars;
    int     upper_chars;
    int     three_byte_chars;
    int     octets_seen;

    function void owe(logic [7:0] octet, logic last_flag);
      octet_t item;
      item.octet     = octet;
      item.last_flag = last_flag;
      owed_q = {owed_q, item};
    endfunction

    function void note_char(logic [7:0] code);
      logic [15:0] cp;
      if (code < 8'h80) begin
        owe(code, 1'b1);
        ascii_chars++;
        return;
      end
      upper_chars++;
      cp = CP850_UPPER[code[6:0]];
      if (cp < OneByteLimit) begin
        owe(cp[7:0], 1'b1);
      end else if (cp < TwoByteLimit) begin
        owe({Lead2Tag, cp[10:6]}, 1'b0);
        owe({ContTag, cp[5:0]}, 1'b1);
      end else begin
        three_byte_chars++;
        owe({Lead3Tag, cp[15:12]}, 1'b0);
        owe({ContTag, cp[11:6]}, 1'b0);
        owe({ContTag, cp[5:0]}, 1'b1);
      end
    endfunction

    function void check_octet(logic [7:0] octet, logic last_flag);
      octet_t want;
      octets_seen++;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected output item byte=%02h last=%0b", octet, last_flag);
        return;
      end
      want = owed_q.pop_front();
      if (want.octet !== octet || want.last_flag !== last_flag) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: output item %0d: expected byte=%02h last=%0b, got byte=%02h last=%0b",
                   octets_seen, want.octet, want.last_flag, octet, last_flag);
      end
    endfunction

    function int owed();
      return owed_q.size();
    endfunction
  endclass

  utf8_scoreboard sb;
  bit             idle_en;
  bit             long_hold_req;
  int unsigned    cycles;

  cp850_to_utf8_transcoder_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .code_byte_i   (code_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .utf8_byte_o   (utf8_byte_o),
    .last_of_char_o(last_of_char_o)
  );

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    code_byte_i   = 8'h00;
    out_stall_i   = 1'b0;
    idle_en       = 1'b1;
    long_hold_req = 1'b0;
    cycles        = 0;
    sb            = new();
  end

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("ERROR: timed out after %0d cycles with %0d bytes still owed", cycles, sb.owed());
      $display("cp850_to_utf8_transcoder_core: mismatch");
      $finish;
    end
  end

  // Output side. A long hold-off, when requested, is counted here so that the sender keeps
  // offering items meanwhile; otherwise, while idle_en is set, stalls come in short random bursts.
  always @(posedge clk_i) begin
    int stall_left;
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LongHoldCycles;
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Output monitor: an item moves when valid is high and stall is low at the edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_octet(utf8_byte_o, last_of_char_o);
  end

  // Offers one character, with an optional idle burst first. Valid is left high after
  // acceptance so back-to-back items never drop it within a step.
  task automatic send_char(input logic [7:0] code);
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_byte_i <= code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_char(code);
  endtask

  task automatic wait_all_returned();
    while (sb.owed() > 0) @(posedge clk_i);
  endtask

  // Upper-half bytes get extra weight since they exercise the multi-byte runs.
  function automatic logic [7:0] pick_char();
    if ($urandom_range(0, 2) == 0)
      return 8'($urandom_range(0, 8'h7F));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  initial begin
    logic [7:0] directed_q[$];

    // Extremes of ASCII and of the table, alternating bit patterns, the first table entry,
    // a plain two-byte case, the only code points above 0x100 that stay two bytes, and
    // several three-byte characters, box-drawing ones among them, including the highest one.
    directed_q = '{8'h00, 8'h7F, 8'h41, 8'h55, 8'hAA, 8'h80, 8'hFF, 8'h9F, 8'hD5,
                   8'hB0, 8'hB3, 8'hC5, 8'hDB, 8'hF2, 8'hFE, 8'h01, 8'hE1};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) send_char(directed_q[i]);

    // The sender pauses here until the block has returned every byte.
    in_valid_i <= 1'b0;
    wait_all_returned();
    @(posedge clk_i);

    repeat (60) send_char(pick_char());

    // Long receiver hold-off with the sender pushing mostly three-byte characters back to
    // back, so the pipeline fills and the input stall must rise.
    idle_en = 1'b0;
    long_hold_req = 1'b1;
    repeat (16) send_char(8'($urandom_range(8'hB0, 8'hDF)));
    idle_en = 1'b1;

    repeat (60) send_char(pick_char());

    // Closing stretch at full rate on both sides.
    idle_en = 1'b0;
    repeat (30) send_char(pick_char());

    in_valid_i <= 1'b0;
    wait_all_returned();
    repeat (10) @(posedge clk_i);

    $display("Covered %0d characters: %0d ASCII, %0d upper half (%0d of them three bytes long).",
             sb.ascii_chars + sb.upper_chars, sb.ascii_chars, sb.upper_chars,
             sb.three_byte_chars);
    $display("Checked %0d UTF-8 bytes with %0d mismatches and %0d left owed.",
             sb.octets_seen, sb.mismatches, sb.owed());
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("cp850_to_utf8_transcoder_core: match");
    end else begin
      $display("cp850_to_utf8_transcoder_core: mismatch");
    end
    $finish;
  end

endmodule

@@ cp850_to_utf8_transcoder_core.f @@
hdl/c850u_pkg.sv
hdl/c850u_encode.sv
hdl/cp850_to_utf8_transcoder_core.sv
hdl/c850u_checker.sv
tb/tb_cp850_to_utf8_transcoder_core.sv
